/* rtl/crc_checked_frame_receiver_defines.svh */
// Assertion macros for the frame receiver. Both expect clk and rst_n in scope.
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every edge outside reset.
`define CCFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame receiver invariant violated");

// Check that a consequence holds in the cycle after its trigger.
`define CCFR_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("frame receiver sequencing violated");

`else

`define CCFR_ASSERT_ALWAYS(lbl, prop)
`define CCFR_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

/* rtl/ccfr_pkg.sv */
package ccfr_pkg;

  localparam int unsigned LENGTH_LIMIT = 1024;

  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [7:0] MARK_A = 8'hA5;
  localparam logic [7:0] MARK_B = 8'hB6;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 11'd1024;
  localparam logic [TICK_W-1:0]  HUNT_TO_RESET = 20'd1000000;
  localparam logic [TICK_W-1:0]  BYTE_TO_RESET = 20'd500000;

  // Shortest frame that can carry a valid verdict: header, CRC, trailer.
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 11'd6;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT0 = 2'd0,
    PH_HUNT1 = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_NOFRAME = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN = 2'd0,
    CFG_HUNT_TO = 2'd1,
    CFG_BYTE_TO = 2'd2
  } cfg_reg_t;

  // One byte of CRC16-Modbus, reflected, LSB first.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

/* rtl/ccfr_in_if.sv */
interface ccfr_in_if import ccfr_pkg::*;;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

/* rtl/ccfr_out_if.sv */
interface ccfr_out_if import ccfr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               byte_valid;
  logic [7:0]         byte_value;
  logic [INDEX_W-1:0] byte_index;
  logic               frame_done;
  logic [1:0]         frame_status;
  logic [COUNT_W-1:0] frame_length;

  modport source (output valid, output byte_valid, output byte_value,
                  output byte_index, output frame_done, output frame_status,
                  output frame_length, input ready);
  modport sink (input valid, input byte_valid, input byte_value,
                input byte_index, input frame_done, input frame_status,
                input frame_length, output ready);
endinterface

/* rtl/crc_checked_frame_receiver.sv */
// Channel  Dir  Handshake           Payload
// in_ch    in   valid/ready         command, rx_byte
// out_ch   out  valid/ready         byte_valid, byte_value, byte_index,
//                                   frame_done, frame_status, frame_length
// cfg_*    in   cfg_wr_en only      cfg_index, cfg_data
//
// One request per clock while the output is not stalled: the byte-wide CRC
// step, the shift line and the compares all settle in the cycle a request is
// taken, and the result lands in the output register on the same edge.
// The output register is the only stage; in_ch.ready is high while it is
// empty or being drained, so a stalled sink stops intake after one result.
// Reset (rst_n low at a clock edge) returns to header hunt and loads the
// register defaults; no clearing pass is needed.
`include "crc_checked_frame_receiver_defines.svh"

module crc_checked_frame_receiver import ccfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ccfr_in_if.sink               in_ch,
  ccfr_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [COUNT_W-1:0] max_len_r;
  logic [TICK_W-1:0]  hunt_to_r;
  logic [TICK_W-1:0]  byte_to_r;

  // Frame state.
  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [TICK_W-1:0]  idle_r, idle_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  // Last four stored bytes, newest at entry 0. Entries fill before use.
  logic [7:0]         recent_r [4];
  logic [7:0]         recent_nxt [4];

  // Result register.
  logic               out_valid_r;
  logic               res_valid;
  logic               res_byte_valid, out_byte_valid_r;
  logic [7:0]         res_byte_value, out_byte_value_r;
  logic [INDEX_W-1:0] res_byte_index, out_byte_index_r;
  logic               res_done, out_done_r;
  status_t            res_status, out_status_r;
  logic [COUNT_W-1:0] res_length, out_length_r;

  // Shared decode.
  logic               accept;
  logic               is_tick;
  logic [7:0]         rx;
  logic [COUNT_W-1:0] limit;
  logic [TICK_W:0]    tick_next;
  logic               hunt_timeout;
  logic               byte_timeout;
  logic               overflow;
  logic               trailer;
  logic [COUNT_W-1:0] count_inc;
  logic [CRC_W-1:0]   crc_fed;
  logic               crc_match;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.command == CMD_TICK);
  assign rx          = in_ch.rx_byte;

  // Effective length limit: the register, capped at the buffer size.
  assign limit = (max_len_r > LENGTH_LIMIT[COUNT_W-1:0]) ? LENGTH_LIMIT[COUNT_W-1:0]
                                                         : max_len_r;

  // A hunt timeout register of zero behaves like one since the count starts at one.
  assign tick_next    = {1'b0, idle_r} + {{TICK_W{1'b0}}, 1'b1};
  assign hunt_timeout = (tick_next >= {1'b0, hunt_to_r});
  assign byte_timeout = (idle_r >= byte_to_r);

  assign overflow  = (byte_count_r >= limit);
  assign count_inc = byte_count_r + {{(COUNT_W-1){1'b0}}, 1'b1};
  assign trailer   = (recent_r[0] == MARK_B) && (rx == MARK_A);

  // The CRC lags the stored bytes by four: feed the byte leaving the shift line.
  assign crc_fed   = (byte_count_r >= 11'd4) ? crc_feed(crc_r, recent_r[3]) : crc_r;
  // Received CRC sits just before the trailer, high byte first.
  assign crc_match = ({recent_r[2], recent_r[1]} == crc_fed);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_HUNT0: begin
          if (is_tick) begin
            phase_nxt = PH_HUNT0;
          end else if (rx == MARK_A) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          if (is_tick) begin
            if (hunt_timeout) begin
              phase_nxt = PH_HUNT0;
            end
          end else if (rx == MARK_B) begin
            phase_nxt = PH_FRAME;
          end else if (rx != MARK_A) begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_FRAME: begin
          if (is_tick) begin
            if (byte_timeout) begin
              phase_nxt = PH_HUNT0;
            end
          end else if (overflow || trailer) begin
            phase_nxt = PH_HUNT0;
          end
        end
        default: phase_nxt = PH_HUNT0;
      endcase
    end
  end

  // Datapath and result for the accepted request.
  always_comb begin
    byte_count_nxt = byte_count_r;
    idle_nxt       = idle_r;
    crc_nxt        = crc_r;
    recent_nxt     = recent_r;
    res_valid      = 1'b0;
    res_byte_valid = 1'b0;
    res_byte_value = '0;
    res_byte_index = '0;
    res_done       = 1'b0;
    res_status     = ST_OK;
    res_length     = '0;

    if (accept) begin
      case (phase_r)
        PH_HUNT0, PH_HUNT1: begin
          if (is_tick) begin
            if (hunt_timeout) begin
              // Hunt gave up: report no_frame with any partial header.
              res_valid      = 1'b1;
              res_done       = 1'b1;
              res_status     = ST_NOFRAME;
              res_length     = byte_count_r;
              byte_count_nxt = '0;
              idle_nxt       = '0;
              crc_nxt        = CRC_INIT;
            end else begin
              idle_nxt = tick_next[TICK_W-1:0];
            end
          end else begin
            idle_nxt = '0;
            if (phase_r == PH_HUNT0) begin
              if (rx == MARK_A) begin
                recent_nxt[0]  = MARK_A;
                byte_count_nxt = 11'd1;
              end
            end else if (rx == MARK_B) begin
              // Header complete; shift the B6 in behind the A5.
              recent_nxt[0]  = MARK_B;
              recent_nxt[1]  = recent_r[0];
              byte_count_nxt = 11'd2;
              crc_nxt        = CRC_INIT;
            end else if (rx == MARK_A) begin
              // Resync on the newest A5; it already sits in entry 0.
              byte_count_nxt = 11'd1;
            end else begin
              byte_count_nxt = '0;
            end
          end
        end
        PH_FRAME: begin
          if (is_tick) begin
            if (byte_timeout) begin
              res_valid      = 1'b1;
              res_done       = 1'b1;
              res_status     = ST_ERROR;
              res_length     = byte_count_r;
              byte_count_nxt = '0;
              idle_nxt       = '0;
              crc_nxt        = CRC_INIT;
            end else begin
              idle_nxt = tick_next[TICK_W-1:0];
            end
          end else if (overflow) begin
            // Drop the byte and end the frame.
            res_valid      = 1'b1;
            res_done       = 1'b1;
            res_status     = ST_ERROR;
            res_length     = byte_count_r;
            byte_count_nxt = '0;
            idle_nxt       = '0;
            crc_nxt        = CRC_INIT;
          end else begin
            idle_nxt       = '0;
            res_valid      = 1'b1;
            res_byte_valid = 1'b1;
            res_byte_value = rx;
            res_byte_index = byte_count_r[INDEX_W-1:0];
            recent_nxt[0]  = rx;
            recent_nxt[1]  = recent_r[0];
            recent_nxt[2]  = recent_r[1];
            recent_nxt[3]  = recent_r[2];
            if (trailer) begin
              res_done       = 1'b1;
              res_status     = (count_inc >= MIN_FRAME_LEN && crc_match) ? ST_OK : ST_ERROR;
              res_length     = count_inc;
              byte_count_nxt = '0;
              crc_nxt        = CRC_INIT;
            end else begin
              byte_count_nxt = count_inc;
              crc_nxt        = crc_fed;
            end
          end
        end
        default: begin
          byte_count_nxt = '0;
          idle_nxt       = '0;
          crc_nxt        = CRC_INIT;
        end
      endcase
    end
  end

  // Control and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT0;
      byte_count_r <= '0;
      idle_r       <= '0;
      crc_r        <= CRC_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      idle_r       <= idle_nxt;
      crc_r        <= crc_nxt;
      if (accept) begin
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Shift line and result payload: no reset.
  always_ff @(posedge clk) begin
    recent_r <= recent_nxt;
    if (accept && res_valid) begin
      out_byte_valid_r <= res_byte_valid;
      out_byte_value_r <= res_byte_value;
      out_byte_index_r <= res_byte_index;
      out_done_r       <= res_done;
      out_status_r     <= res_status;
      out_length_r     <= res_length;
    end
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      hunt_to_r <= HUNT_TO_RESET;
      byte_to_r <= BYTE_TO_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_LEN: max_len_r <= cfg_data[COUNT_W-1:0];
        CFG_HUNT_TO: hunt_to_r <= cfg_data[TICK_W-1:0];
        CFG_BYTE_TO: byte_to_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_valid   = out_byte_valid_r;
  assign out_ch.byte_value   = out_byte_value_r;
  assign out_ch.byte_index   = out_byte_index_r;
  assign out_ch.frame_done   = out_done_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.frame_length = out_length_r;

  `CCFR_ASSERT_ALWAYS(a_frame_has_header, (phase_r != PH_FRAME) || (byte_count_r >= 11'd2))
  `CCFR_ASSERT_ALWAYS(a_hunt_count_small, (phase_r == PH_FRAME) || (byte_count_r <= 11'd1))
  `CCFR_ASSERT_ALWAYS(a_count_in_buffer, byte_count_r <= LENGTH_LIMIT[COUNT_W-1:0])
  `CCFR_ASSERT_NEXT(a_verdict_rehunts, accept && res_done, phase_r == PH_HUNT0 && byte_count_r == '0)
  `CCFR_ASSERT_ALWAYS(a_ok_is_long, !(out_valid_r && out_done_r && out_status_r == ST_OK) || (out_length_r >= MIN_FRAME_LEN))

endmodule
